### hdl/btr_pkg.sv
package btr_pkg;

    localparam int GLYPH_ROWS = 8;
    localparam int ROW_BITS   = 8;
    localparam int CELLS      = GLYPH_ROWS * ROW_BITS;
    localparam int CELL_IDX_W = $clog2(CELLS);
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    // screen coordinate range, tied to the 16-bit pixel ports and cursor
    localparam int COORD_BITS = 16;

    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [15:0] CURSOR_MAX   = 16'hFFFF;

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_WIDTH   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_AREA_HEIGHT  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_PEN_COLOR    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_WRAP_MODE    = 3'd7;

    typedef struct packed {
        logic [3:0]  glyph_width;
        logic [3:0]  glyph_height;
        logic [15:0] origin_x;
        logic [15:0] origin_y;
        logic [15:0] area_width;
        logic [15:0] area_height;
        logic [23:0] pen_color;
        logic        wrap_mode;
    } cfg_t;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_PLACE = 5'b00010,
        ST_CHECK = 5'b00100,
        ST_MASK  = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    typedef struct packed {
        logic accept;
        logic place;
        logic check;
        logic build_mask;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic mask_empty;
    } status_t;

    function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[16] ? CURSOR_MAX : s[15:0];
    endfunction

endpackage

### hdl/btr_cfg_regs.sv
module btr_cfg_regs
    import btr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  logic [CFG_IDX_W-1:0]  wr_index,
    input  logic [CFG_DATA_W-1:0] wr_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (wr_index)
                REG_GLYPH_WIDTH:  cfg_next.glyph_width  = wr_data[3:0];
                REG_GLYPH_HEIGHT: cfg_next.glyph_height = wr_data[3:0];
                REG_ORIGIN_X:     cfg_next.origin_x     = wr_data[15:0];
                REG_ORIGIN_Y:     cfg_next.origin_y     = wr_data[15:0];
                REG_AREA_WIDTH:   cfg_next.area_width   = wr_data[15:0];
                REG_AREA_HEIGHT:  cfg_next.area_height  = wr_data[15:0];
                REG_PEN_COLOR:    cfg_next.pen_color    = wr_data[23:0];
                REG_WRAP_MODE:    cfg_next.wrap_mode    = wr_data[0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.glyph_width  <= 4'd8;
            cfg_reg.glyph_height <= 4'd8;
            cfg_reg.origin_x     <= 16'd0;
            cfg_reg.origin_y     <= 16'd0;
            cfg_reg.area_width   <= 16'hFFFF;
            cfg_reg.area_height  <= 16'hFFFF;
            cfg_reg.pen_color    <= 24'hFFFFFF;
            cfg_reg.wrap_mode    <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### hdl/btr_ctrl.sv
module btr_ctrl
    import btr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_valid) state_next = ST_PLACE;
            ST_PLACE: state_next = ST_CHECK;
            ST_CHECK: state_next = ST_MASK;
            ST_MASK:  state_next = ST_EMIT;
            ST_EMIT:  if (status.mask_empty) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign cmd.accept     = (state_reg == ST_IDLE) && in_valid;
    assign cmd.place      = (state_reg == ST_PLACE);
    assign cmd.check      = (state_reg == ST_CHECK);
    assign cmd.build_mask = (state_reg == ST_MASK);
    assign cmd.emit       = (state_reg == ST_EMIT);

endmodule

### hdl/btr_datapath.sv
module btr_datapath
    import btr_pkg::*;
#(
    parameter int MAX_GLYPH_WIDTH  = 8,
    parameter int MAX_GLYPH_HEIGHT = 8
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic [7:0]  char_code,
    input  logic [63:0] glyph_rows,
    input  logic        new_string,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] pixel_x,
    output logic [15:0] pixel_y,
    output logic [23:0] pixel_color,
    output logic        last_pixel
);

    localparam int PX_W = 18;

    // captured beat
    logic [7:0]  code_reg;
    logic [63:0] rows_reg;
    logic        ns_reg;

    // text cursor state
    logic [15:0] cursor_x_reg, cursor_x_next;
    logic [15:0] cursor_y_reg, cursor_y_next;
    logic        stopped_reg, stopped_next;

    // placement results
    logic [15:0] cx1_reg, cy1_reg;
    logic        bad_reg, nl_reg;
    logic        draw_reg, draw_next;
    logic [16:0] bx_reg, by_reg;

    logic [CELLS-1:0] mask_reg, mask_next;

    logic        out_valid_reg, out_valid_next;
    logic [15:0] px_reg, py_reg;
    logic [23:0] color_reg;
    logic        last_reg;

    logic [3:0]  w, h, adv;
    logic [15:0] cx_e, cy_e;
    logic        nl, wrap_x, bad;
    logic [15:0] cy_inc;
    logic        h_over;

    logic [7:0]       col_ok, row_ok;
    logic [CELLS-1:0] scan_mask;
    logic [CELLS-1:0] lowest;
    logic [CELL_IDX_W-1:0] idx;
    logic        load;
    logic [PX_W-1:0] px_full, py_full;

    // clamped glyph size and advance (w is at most 8, so w/5 is 1 from 5 up)
    assign w   = (cfg.glyph_width > 4'(MAX_GLYPH_WIDTH)) ? 4'(MAX_GLYPH_WIDTH)
                                                         : cfg.glyph_width;
    assign h   = (cfg.glyph_height > 4'(MAX_GLYPH_HEIGHT)) ? 4'(MAX_GLYPH_HEIGHT)
                                                           : cfg.glyph_height;
    assign adv = w - ((w >= 4'd5) ? 4'd1 : 4'd0);

    // placement: new string clears the cursor first
    assign cx_e   = ns_reg ? 16'd0 : cursor_x_reg;
    assign cy_e   = ns_reg ? 16'd0 : cursor_y_reg;
    assign nl     = (code_reg == NEWLINE_CODE);
    assign bad    = cfg.wrap_mode && ((adv == 4'd0) || (cfg.area_width < 16'(w))
                    || (cfg.area_height < 16'(h)));
    assign wrap_x = cfg.wrap_mode && !nl
                    && (({1'b0, cx_e} + 17'(w)) > {1'b0, cfg.area_width});
    assign cy_inc = sat_add16(cy_e, 16'(h));

    assign h_over = cfg.wrap_mode && (({1'b0, cy1_reg} + 17'(h)) > {1'b0, cfg.area_height});

    always_comb
    begin
        cursor_x_next = cursor_x_reg;
        cursor_y_next = cursor_y_reg;
        stopped_next  = stopped_reg;
        draw_next     = 1'b0;
        if (cmd.place && ns_reg)
        begin
            cursor_x_next = 16'd0;
            cursor_y_next = 16'd0;
            stopped_next  = 1'b0;
        end
        else if (cmd.check && !stopped_reg)
        begin
            if (bad_reg)
            begin
                stopped_next = 1'b1;
            end
            else if (nl_reg)
            begin
                cursor_x_next = 16'd0;
                cursor_y_next = cy1_reg;
                stopped_next  = h_over;
            end
            else if (h_over)
            begin
                cursor_x_next = cx1_reg;
                cursor_y_next = cy1_reg;
                stopped_next  = 1'b1;
            end
            else
            begin
                cursor_x_next = sat_add16(cx1_reg, 16'(adv));
                cursor_y_next = cy1_reg;
                draw_next     = 1'b1;
            end
        end
    end

    // per-column and per-row coordinate range checks
    always_comb
    begin
        for (int i = 0; i < ROW_BITS; i++)
        begin
            col_ok[i] = (((PX_W'(bx_reg) + PX_W'(i)) >> COORD_BITS) == '0);
        end
        for (int j = 0; j < GLYPH_ROWS; j++)
        begin
            row_ok[j] = (((PX_W'(by_reg) + PX_W'(j)) >> COORD_BITS) == '0);
        end
    end

    // scan-ordered mask: cell 8j+i is column i of row j
    always_comb
    begin
        logic [7:0] row_byte;
        logic [3:0] sel;
        for (int j = 0; j < GLYPH_ROWS; j++)
        begin
            row_byte = rows_reg[ROW_BITS*j +: ROW_BITS];
            for (int i = 0; i < ROW_BITS; i++)
            begin
                sel = w - 4'(i) - 4'd1;
                scan_mask[ROW_BITS*j + i] = (4'(i) < w) && (4'(j) < h)
                                            && row_byte[sel[2:0]]
                                            && col_ok[i] && row_ok[j];
            end
        end
    end

    // next set cell in scan order
    assign lowest = mask_reg & (~mask_reg + 1'b1);

    always_comb
    begin
        idx = '0;
        for (int k = 0; k < CELLS; k++)
        begin
            if (lowest[k])
            begin
                idx = idx | CELL_IDX_W'(k);
            end
        end
    end

    assign load    = cmd.emit && (mask_reg != '0) && (!out_valid_reg || !out_stall);
    assign px_full = PX_W'(bx_reg) + PX_W'(idx[2:0]);
    assign py_full = PX_W'(by_reg) + PX_W'(idx[CELL_IDX_W-1:3]);

    always_comb
    begin
        mask_next = mask_reg;
        if (cmd.build_mask)
        begin
            mask_next = draw_reg ? scan_mask : '0;
        end
        else if (load)
        begin
            mask_next = mask_reg & ~lowest;
        end
    end

    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_x_reg  <= 16'd0;
            cursor_y_reg  <= 16'd0;
            stopped_reg   <= 1'b0;
            draw_reg      <= 1'b0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cursor_x_reg  <= cursor_x_next;
            cursor_y_reg  <= cursor_y_next;
            stopped_reg   <= stopped_next;
            if (cmd.check)
            begin
                draw_reg <= draw_next;
            end
            mask_reg      <= mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            code_reg <= char_code;
            rows_reg <= glyph_rows;
            ns_reg   <= new_string;
        end
        if (cmd.place)
        begin
            cx1_reg <= (nl || wrap_x) ? 16'd0 : cx_e;
            cy1_reg <= (nl || wrap_x) ? cy_inc : cy_e;
            bad_reg <= bad;
            nl_reg  <= nl;
        end
        if (cmd.check)
        begin
            bx_reg <= {1'b0, cfg.origin_x} + {1'b0, cx1_reg};
            by_reg <= {1'b0, cfg.origin_y} + {1'b0, cy1_reg};
        end
        if (load)
        begin
            px_reg    <= px_full[15:0];
            py_reg    <= py_full[15:0];
            color_reg <= cfg.pen_color;
            last_reg  <= ((mask_reg & ~lowest) == '0);
        end
    end

    assign status.mask_empty = (mask_reg == '0);
    assign out_valid         = out_valid_reg;
    assign pixel_x           = px_reg;
    assign pixel_y           = py_reg;
    assign pixel_color       = color_reg;
    assign last_pixel        = last_reg;

endmodule

### hdl/bitmap_text_rasterizer_core.sv
// Bitmap text rasterizer. Each input beat carries one character and its glyph
// bitmap (row j in glyph_rows byte j, leftmost pixel in the glyph's top used
// bit); the block emits one output beat per set glyph pixel in screen
// coordinates, rows top to bottom and left to right, with last_pixel marking
// the final beat of the character. A character that draws nothing produces no
// beat. The cursor is kept relative to origin_x/origin_y and advances by
// width - width/5; a newline (code 10) returns to column 0 and moves down one
// glyph height. With wrap_mode set the text wraps at area_width and a line that
// would pass area_height stops the string until a beat with new_string set.
// Sequence: a character passes through accept, place, range check, mask build
// and emit, which sends its set pixels and closes once the mask runs dry; a
// newline or an empty glyph passes through the same steps with no pixel beat,
// and output stalls hold emit back. The pixel rate is set by the single scan
// unit, which pulls the next set cell out of a 64-bit scan mask each cycle
// unless the output register is stalled. The final pixel of one character
// may still wait in the output register while the next character is taken in.
// Configuration writes are always ready and must only be issued while no
// character is in flight.
module bitmap_text_rasterizer_core
    import btr_pkg::*;
#(
    parameter int MAX_GLYPH_WIDTH  = 8,
    parameter int MAX_GLYPH_HEIGHT = 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,

    // configuration write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,

    // character channel
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic [7:0]            char_code,
    input  logic [63:0]           glyph_rows,
    input  logic                  new_string,

    // pixel channel
    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [15:0]           pixel_x,
    output logic [15:0]           pixel_y,
    output logic [23:0]           pixel_color,
    output logic                  last_pixel
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    // register file takes a write every cycle
    assign cfg_ready = 1'b1;

    btr_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // sequencer: accept, place cursor, range check, build mask, emit
    btr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // cursor, scan mask and output register
    btr_datapath #(
        .MAX_GLYPH_WIDTH  (MAX_GLYPH_WIDTH),
        .MAX_GLYPH_HEIGHT (MAX_GLYPH_HEIGHT)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .char_code   (char_code),
        .glyph_rows  (glyph_rows),
        .new_string  (new_string),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .pixel_color (pixel_color),
        .last_pixel  (last_pixel)
    );

endmodule

### tb/tb_top.sv
module tb_top
    import btr_pkg::*;
();

    // glyph limits and screen range of the block as instantiated (default parameters)
    localparam int unsigned GLYPH_MAX_W = 8;
    localparam int unsigned GLYPH_MAX_H = 8;
    localparam int unsigned COORD_MAX   = 65535;

    // settle time lets a blank character or a newline finish inside the block
    localparam int SETTLE_CYCLES  = 12;
    localparam int TAIL_CYCLES    = 40;
    localparam int QUIET_LIMIT    = 4000;
    localparam int HOLD_CYCLES    = 600;
    localparam int BLOCKS         = 20;
    localparam int CHARS_PER_BLK  = 23;
    localparam int MAX_REPORTS    = 100;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [23:0] color;
        logic        last;
    } pixel_t;

    // directed script: register writes, characters checked by the predictor,
    // characters that must draw nothing, characters that draw exactly one pixel
    typedef enum logic [1:0] {
        STEP_WRITE,
        STEP_PREDICTED,
        STEP_BLANK,
        STEP_ONE_PIXEL
    } step_kind_t;

    typedef struct packed {
        step_kind_t            kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        logic [7:0]            code;
        logic [63:0]           rows;
        logic                  fresh;
        logic [15:0]           at_x;
        logic [15:0]           at_y;
    } script_step_t;

    localparam logic [63:0] ALL_SET = 64'hFFFF_FFFF_FFFF_FFFF;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic [7:0]            char_code = '0;
    logic [63:0]           glyph_rows = '0;
    logic                  new_string = 1'b0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [15:0]           pixel_x;
    logic [15:0]           pixel_y;
    logic [23:0]           pixel_color;
    logic                  last_pixel;

    // shadow copy of the registers and the text cursor
    cfg_t        shadow_cfg = '{4'd8, 4'd8, 16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 24'hFFFFFF, 1'b0};
    int unsigned text_x = 0;
    int unsigned text_y = 0;
    logic        text_halted = 1'b0;

    pixel_t       char_pixels[$];
    pixel_t       owed_pixels[$];
    script_step_t script[$];

    int sender_idle_pct = 0;
    int stall_pct = 0;
    int idle_plan[4] = '{0, 79, 0, 11};
    int stall_plan[4] = '{0, 0, 79, 11};
    logic hold_active = 1'b0;
    event hold_go;

    int error_count = 0;
    int chars_sent = 0;
    int chars_drawn = 0;
    int beats_checked = 0;
    int writes_done = 0;
    int quiet_cycles = 0;

    bitmap_text_rasterizer_core dut (.*);

    always #5 clk = ~clk;

    // cursor counters stop at the top of their 16-bit range
    function automatic int unsigned capped_add(int unsigned a, int unsigned b);
        return (a + b > 65535) ? 65535 : a + b;
    endfunction

    // works out the pixel beats of one character into char_pixels and moves the cursor;
    // returns 0 when the string was already stopped and the character is ignored
    function automatic logic rasterize_char(logic [7:0] code, logic [63:0] rows, logic fresh);
        int unsigned gw;
        int unsigned gh;
        int unsigned advance;
        int unsigned bx;
        int unsigned by;
        int unsigned px;
        int unsigned py;
        gw = (shadow_cfg.glyph_width > GLYPH_MAX_W) ? GLYPH_MAX_W : shadow_cfg.glyph_width;
        gh = (shadow_cfg.glyph_height > GLYPH_MAX_H) ? GLYPH_MAX_H : shadow_cfg.glyph_height;
        advance = gw - gw / 5;
        char_pixels.delete();
        if (fresh)
        begin
            text_x = 0;
            text_y = 0;
            text_halted = 1'b0;
        end
        if (text_halted)
            return 1'b0;
        if (!shadow_cfg.wrap_mode)
        begin
            // plain layout: no wrap, no clip to the area
            if (code == NEWLINE_CODE)
            begin
                text_x = 0;
                text_y = capped_add(text_y, gh);
                return 1'b1;
            end
        end
        else
        begin
            // zero advance or an area smaller than one glyph stops the string
            if (advance == 0 || shadow_cfg.area_width < gw || shadow_cfg.area_height < gh)
            begin
                text_halted = 1'b1;
                return 1'b1;
            end
            if (code == NEWLINE_CODE)
            begin
                text_x = 0;
                text_y = capped_add(text_y, gh);
                if (text_y + gh > shadow_cfg.area_height)
                    text_halted = 1'b1;
                return 1'b1;
            end
            if (text_x + gw > shadow_cfg.area_width)
            begin
                text_x = 0;
                text_y = capped_add(text_y, gh);
            end
            if (text_y + gh > shadow_cfg.area_height)
            begin
                text_halted = 1'b1;
                return 1'b1;
            end
        end
        bx = shadow_cfg.origin_x + text_x;
        by = shadow_cfg.origin_y + text_y;
        for (int unsigned j = 0; j < gh; j++)
        begin
            for (int unsigned i = 0; i < gw; i++)
            begin
                px = bx + i;
                py = by + j;
                // pixels past the screen range are dropped
                if (rows[8 * j + gw - 1 - i] && px <= COORD_MAX && py <= COORD_MAX)
                    char_pixels.push_back('{px[15:0], py[15:0], shadow_cfg.pen_color, 1'b0});
            end
        end
        if (char_pixels.size() != 0)
            char_pixels[char_pixels.size() - 1].last = 1'b1;
        text_x = capped_add(text_x, advance);
        return 1'b1;
    endfunction

    function automatic void script_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        script.push_back('{STEP_WRITE, idx, value, 8'd0, 64'd0, 1'b0, 16'd0, 16'd0});
    endfunction

    function automatic void script_char(step_kind_t kind, logic [7:0] code, logic [63:0] rows,
                                        logic fresh, logic [15:0] at_x, logic [15:0] at_y);
        script.push_back('{kind, '0, '0, code, rows, fresh, at_x, at_y});
    endfunction

    task automatic report_mismatch(string what);
        error_count++;
        // keep the log short once things go badly wrong
        if (error_count <= MAX_REPORTS)
            $display("tb_top: mismatch: %s", what);
    endtask

    // register writes only with nothing in flight: drain, then let a blank char finish
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
        in_valid <= 1'b0;
        while (owed_pixels.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        case (idx)
            REG_GLYPH_WIDTH:  shadow_cfg.glyph_width = value[3:0];
            REG_GLYPH_HEIGHT: shadow_cfg.glyph_height = value[3:0];
            REG_ORIGIN_X:     shadow_cfg.origin_x = value[15:0];
            REG_ORIGIN_Y:     shadow_cfg.origin_y = value[15:0];
            REG_AREA_WIDTH:   shadow_cfg.area_width = value[15:0];
            REG_AREA_HEIGHT:  shadow_cfg.area_height = value[15:0];
            REG_PEN_COLOR:    shadow_cfg.pen_color = value[23:0];
            REG_WRAP_MODE:    shadow_cfg.wrap_mode = value[0];
            default: ;
        endcase
        writes_done++;
    endtask

    // offers one character beat; valid stays up across back-to-back beats
    task automatic send_char(step_kind_t kind, logic [7:0] code, logic [63:0] rows, logic fresh,
                             logic [15:0] at_x, logic [15:0] at_y);
        logic live;
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= code;
        glyph_rows <= rows;
        new_string <= fresh;
        do
            @(posedge clk);
        while (!(in_valid && !in_stall));
        live = rasterize_char(code, rows, fresh);
        chars_sent++;
        if (live)
            chars_drawn++;
        case (kind)
            STEP_PREDICTED:
                foreach (char_pixels[k])
                    owed_pixels.push_back(char_pixels[k]);
            STEP_ONE_PIXEL:
                owed_pixels.push_back('{at_x, at_y, shadow_cfg.pen_color, 1'b1});
            default: ;
        endcase
    endtask

    // writes every register for one random block; narrow registers get junk in the upper bits
    task automatic setup_block(int blk);
        logic [3:0]  gw;
        logic [3:0]  gh;
        logic [15:0] ox;
        logic [15:0] oy;
        logic [15:0] aw;
        logic [15:0] ah;
        logic [23:0] color;
        logic [23:0] junk;
        int unsigned wv;
        int unsigned hv;
        gw = 4'($urandom_range(1, 8));
        gh = 4'($urandom_range(1, 8));
        case (blk % 10)
            0: begin gw = 4'd8; gh = 4'd8; end
            1: begin gw = 4'd1; gh = 4'd1; end
            5: gw = 4'd0;
            7: begin gw = 4'($urandom_range(9, 15)); gh = 4'($urandom_range(9, 15)); end
            8: gh = 4'd0;
            default: ;
        endcase
        wv = (gw > GLYPH_MAX_W) ? GLYPH_MAX_W : ((gw == 0) ? 1 : 32'(gw));
        hv = (gh > GLYPH_MAX_H) ? GLYPH_MAX_H : ((gh == 0) ? 1 : 32'(gh));
        ox = 16'($urandom_range(0, 3000));
        oy = 16'($urandom_range(0, 3000));
        case (blk % 6)
            0: begin ox = 16'd0; oy = 16'd0; end
            // text runs off the bottom right corner of the screen
            4:
            begin
                ox = 16'hFFFF - 16'($urandom_range(0, 12));
                oy = 16'hFFFF - 16'($urandom_range(0, 12));
            end
            default: ;
        endcase
        case (blk % 4)
            0: aw = 16'hFFFF;
            1: aw = 16'($urandom_range(wv, 12 * wv));
            2: aw = (blk == 2) ? 16'd0 : 16'($urandom_range(1, 9));
            default: aw = 16'($urandom_range(0, 300));
        endcase
        case (blk % 5)
            0: ah = 16'hFFFF;
            1: ah = 16'($urandom_range(hv, 6 * hv));
            2: ah = 16'($urandom_range(0, 9));
            3: ah = (blk == 3) ? 16'd0 : 16'($urandom_range(hv, 4 * hv));
            default: ah = 16'($urandom_range(0, 200));
        endcase
        color = 24'($urandom);
        if (blk == 0)
            color = 24'h000000;
        else if (blk == 1)
            color = 24'hFFFFFF;
        junk = 24'($urandom);
        write_reg(REG_GLYPH_WIDTH, {junk[23:4], gw});
        junk = 24'($urandom);
        write_reg(REG_GLYPH_HEIGHT, {junk[23:4], gh});
        junk = 24'($urandom);
        write_reg(REG_ORIGIN_X, {junk[23:16], ox});
        junk = 24'($urandom);
        write_reg(REG_ORIGIN_Y, {junk[23:16], oy});
        junk = 24'($urandom);
        write_reg(REG_AREA_WIDTH, {junk[23:16], aw});
        junk = 24'($urandom);
        write_reg(REG_AREA_HEIGHT, {junk[23:16], ah});
        write_reg(REG_PEN_COLOR, color);
        junk = 24'($urandom);
        // wrap and clip in two blocks of three
        write_reg(REG_WRAP_MODE, {junk[23:1], 1'(blk % 3 != 0)});
    endtask

    // receiver: random stalls, plus one long hold-off counted here
    always @(posedge clk)
    begin
        out_stall <= hold_active || ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        forever
        begin
            @(hold_go);
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_active = 1'b0;
        end
    end

    // compare each pixel beat with the oldest one owed
    always @(posedge clk)
    begin
        pixel_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            beats_checked++;
            if (owed_pixels.size() == 0)
                report_mismatch($sformatf("unexpected pixel beat x=%0d y=%0d", pixel_x, pixel_y));
            else
            begin
                want = owed_pixels.pop_front();
                if (pixel_x !== want.x)
                    report_mismatch($sformatf("pixel_x %0d, expected %0d", pixel_x, want.x));
                if (pixel_y !== want.y)
                    report_mismatch($sformatf("pixel_y %0d, expected %0d", pixel_y, want.y));
                if (pixel_color !== want.color)
                    report_mismatch($sformatf("pixel_color %h, expected %h at (%0d,%0d)",
                                              pixel_color, want.color, want.x, want.y));
                if (last_pixel !== want.last)
                    report_mismatch($sformatf("last_pixel %b, expected %b at (%0d,%0d)",
                                              last_pixel, want.last, want.x, want.y));
            end
        end
    end

    // watchdog: no beat on any channel for too long ends the run
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles == QUIET_LIMIT)
        begin
            $display("tb_top: stuck, %0d pixel beats still owed", owed_pixels.size());
            $display("tb_top: done, errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic        fresh;
        logic [7:0]  code;
        logic [63:0] rows;

        // plain layout straight out of reset: 8x8 glyphs, origin 0, white pen
        script_char(STEP_ONE_PIXEL, 8'h41, 64'h1, 1'b1, 16'd7, 16'd0);
        // character zero is an ordinary glyph, drawn as a full block
        script_char(STEP_PREDICTED, 8'h00, ALL_SET, 1'b0, 16'd0, 16'd0);
        script_char(STEP_BLANK, NEWLINE_CODE, ALL_SET, 1'b0, 16'd0, 16'd0);
        // bottom row, leftmost pixel of the second line
        script_char(STEP_ONE_PIXEL, 8'hFF, 64'h8000_0000_0000_0000, 1'b0, 16'd0, 16'd15);
        script_char(STEP_BLANK, 8'h20, 64'h0, 1'b0, 16'd0, 16'd0);
        // glyphs hanging past the screen edge lose their outer pixels
        script_write(REG_ORIGIN_X, 24'd65530);
        script_write(REG_ORIGIN_Y, 24'd65533);
        script_char(STEP_PREDICTED, 8'h5A, ALL_SET, 1'b1, 16'd0, 16'd0);
        script_char(STEP_PREDICTED, 8'hFF, 64'hA5C3_0F96_3C5A_E781, 1'b0, 16'd0, 16'd0);
        script_write(REG_ORIGIN_X, 24'hFFFF);
        script_write(REG_ORIGIN_Y, 24'hFFFF);
        script_char(STEP_ONE_PIXEL, 8'h2E, 64'h80, 1'b1, 16'hFFFF, 16'hFFFF);
        // oversized width is clamped, zero height draws nothing
        script_write(REG_GLYPH_WIDTH, 24'd15);
        script_write(REG_GLYPH_HEIGHT, 24'd0);
        script_char(STEP_BLANK, 8'h41, ALL_SET, 1'b1, 16'd0, 16'd0);
        // zero width draws nothing
        script_write(REG_GLYPH_WIDTH, 24'd0);
        script_write(REG_GLYPH_HEIGHT, 24'd15);
        script_char(STEP_BLANK, 8'h41, ALL_SET, 1'b0, 16'd0, 16'd0);
        // wrap mode in a 20x16 box: two glyphs per line, two lines
        script_write(REG_ORIGIN_X, 24'd100);
        script_write(REG_ORIGIN_Y, 24'd200);
        script_write(REG_GLYPH_WIDTH, 24'd8);
        script_write(REG_GLYPH_HEIGHT, 24'd8);
        script_write(REG_AREA_WIDTH, 24'd20);
        script_write(REG_AREA_HEIGHT, 24'd16);
        script_write(REG_PEN_COLOR, 24'h000000);
        script_write(REG_WRAP_MODE, 24'd1);
        script_char(STEP_PREDICTED, 8'h61, ALL_SET, 1'b1, 16'd0, 16'd0);
        script_char(STEP_PREDICTED, 8'h62, ALL_SET, 1'b0, 16'd0, 16'd0);
        // third glyph wraps onto the second line
        script_char(STEP_PREDICTED, 8'h63, 64'h0F1E_3C78_F0E1_C387, 1'b0, 16'd0, 16'd0);
        // newline would leave the box: string stops, and stays stopped
        script_char(STEP_BLANK, NEWLINE_CODE, ALL_SET, 1'b0, 16'd0, 16'd0);
        script_char(STEP_BLANK, 8'h64, ALL_SET, 1'b0, 16'd0, 16'd0);
        // new string clears the stop
        script_char(STEP_ONE_PIXEL, 8'h65, 64'h1, 1'b1, 16'd107, 16'd200);
        // area narrower than a glyph
        script_write(REG_AREA_WIDTH, 24'd5);
        script_char(STEP_BLANK, 8'h66, ALL_SET, 1'b1, 16'd0, 16'd0);
        // area of zero height
        script_write(REG_AREA_WIDTH, 24'hFFFF);
        script_write(REG_AREA_HEIGHT, 24'd0);
        script_char(STEP_BLANK, 8'h67, ALL_SET, 1'b1, 16'd0, 16'd0);
        // zero advance in wrap mode
        script_write(REG_AREA_HEIGHT, 24'hFFFF);
        script_write(REG_GLYPH_WIDTH, 24'd0);
        script_char(STEP_BLANK, 8'h68, ALL_SET, 1'b1, 16'd0, 16'd0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[k])
        begin
            if (script[k].kind == STEP_WRITE)
                write_reg(script[k].reg_index, script[k].reg_value);
            else
                send_char(script[k].kind, script[k].code, script[k].rows, script[k].fresh,
                          script[k].at_x, script[k].at_y);
        end

        // random blocks; idling plan changes every five blocks
        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            setup_block(blk);
            sender_idle_pct = idle_plan[blk / 5];
            stall_pct = stall_plan[blk / 5];
            // receiver holds off while characters keep coming, so the input backs up
            if (blk == 3)
                -> hold_go;
            fresh = 1'b1;
            for (int n = 0; n < CHARS_PER_BLK; n++)
            begin
                if ($urandom_range(99) < 12)
                    code = NEWLINE_CODE;
                else
                    code = 8'($urandom_range(255));
                case ($urandom_range(9))
                    0: rows = ALL_SET;
                    1: rows = 64'd0;
                    2: rows = 64'd1 << $urandom_range(63);
                    default: rows = {$urandom, $urandom};
                endcase
                send_char(STEP_PREDICTED, code, rows, fresh, 16'd0, 16'd0);
                // mostly continue the string, sometimes start over
                fresh = ($urandom_range(99) < 12);
            end
        end

        in_valid <= 1'b0;
        while (owed_pixels.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("tb_top: %0d characters (%0d not ignored), %0d pixel beats, %0d register writes",
                 chars_sent, chars_drawn, beats_checked, writes_done);
        $display("tb_top: %0d random settings in wrap and plain layout over four idling phases",
                 BLOCKS);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule
